[design/pbp_pkg.sv]
package pbp_pkg;

  localparam int NUM_BLOCKS_DEF = 4;
  localparam int BLOCK_SIZE_DEF = 4;
  localparam int IDX_W          = 4;
  localparam int VAL_W          = 16;
  localparam int PROD_W         = 2 * VAL_W;
  localparam int RES_W          = 48;
  localparam int IN_TDATA_W     = 32;
  localparam int CHAIN_LEN      = 2;
  localparam int DRAIN_CYC      = 4;
  localparam int DRAIN_W        = 3;

  typedef enum logic [1:0] {
    MODE_WR_A    = 2'd0,
    MODE_WR_B    = 2'd1,
    MODE_COMPUTE = 2'd2,
    MODE_READ    = 2'd3
  } mode_e;

  // one term pair per cell position; cell n multiplies a[n] by b[n]
  typedef struct packed {
    logic                              valid;
    logic                              first;
    logic                              last;
    logic signed [RES_W-1:0]           sum;
    logic        [CHAIN_LEN-1:0][VAL_W-1:0] a;
    logic        [CHAIN_LEN-1:0][VAL_W-1:0] b;
  } stage_t;

endpackage

[design/pbp_ram.sv]
module pbp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/pbp_mac_cell.sv]
module pbp_mac_cell #(
  parameter int Idx  = 0,
  parameter int TagW = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbp_pkg::stage_t   stage_i,
  input  logic [TagW-1:0]   tag_i,
  output pbp_pkg::stage_t   stage_o,
  output logic [TagW-1:0]   tag_o
);
  import pbp_pkg::*;

  logic signed [PROD_W-1:0] prod;
  stage_t                   stage_d;
  stage_t                   stage_q;
  logic                     valid_q;

  assign prod = $signed(stage_i.a[Idx]) * $signed(stage_i.b[Idx]);

  always_comb begin
    stage_d     = stage_i;
    stage_d.sum = stage_i.sum + RES_W'(prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
    tag_o   <= tag_i;
  end

  always_comb begin
    stage_o       = stage_q;
    stage_o.valid = valid_q;
  end

endmodule

[design/symmetry_preserving_block_product_top.sv]
// Block-symmetric matrix product engine. One request per item on the input stream:
// write an A or B element (shared block cells, so block (I,J) and (J,I) alias),
// start a compute, or read a result element. Every request returns one response;
// tdata carries the 48-bit signed result (zero except for reads), tuser flags a read
// made before any compute or one that sees results made stale by a later write. Intake
// stalls until each response has left, and a compute also stalls it for its whole pass:
// each result element is a dot product of 2*N terms fed through a chain of two
// multiply-add cells, one term pair per cycle, limited by one read port per operand
// memory copy. No clearing pass after reset; results read as zero until the first
// compute.
module symmetry_preserving_block_product_top #(
  parameter int NumBlocks = pbp_pkg::NUM_BLOCKS_DEF,
  parameter int BlockSize = pbp_pkg::BLOCK_SIZE_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // mode[1:0], row[5:2], col[9:6], value[25:10], zero fill
  input  logic [pbp_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // result_value[47:0]
  output logic [pbp_pkg::RES_W-1:0]   m_axis_tdata_o,
  // status[0]
  output logic                        m_axis_tuser_o
);
  import pbp_pkg::*;

  localparam int Dim    = NumBlocks * BlockSize;
  localparam int Bsq    = BlockSize * BlockSize;
  localparam int NPairs = (NumBlocks * (NumBlocks + 1)) / 2;
  localparam int Depth  = NPairs * Bsq;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int BW     = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int EW     = (BlockSize > 1) ? $clog2(BlockSize) : 1;
  localparam int OW     = (Bsq > 1) ? $clog2(Bsq) : 1;
  localparam int NRows  = 1 << IDX_W;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_RUN, ST_DRAIN} state_e;

  function automatic logic [OW-1:0] elem_off(input logic [EW-1:0] r, input logic [EW-1:0] c);
    return OW'(OW'(r) * OW'(BlockSize)) + OW'(c);
  endfunction

  // constant tables
  logic [BW-1:0] blk_tab [NRows];
  logic [EW-1:0] sub_tab [NRows];
  logic [AW-1:0] base_tab [NumBlocks][NumBlocks];

  for (genvar g = 0; g < NRows; g++) begin : g_rowtab
    assign blk_tab[g] = BW'(g / BlockSize);
    assign sub_tab[g] = EW'(g % BlockSize);
  end
  for (genvar gx = 0; gx < NumBlocks; gx++) begin : g_bx
    for (genvar gy = 0; gy < NumBlocks; gy++) begin : g_by
      localparam int Hi = (gx > gy) ? gx : gy;
      localparam int Lo = (gx > gy) ? gy : gx;
      assign base_tab[gx][gy] = AW'(((Hi * (Hi + 1)) / 2 + Lo) * Bsq);
    end
  end

  // input decode
  mode_e                  in_mode;
  logic [IDX_W-1:0]       in_row;
  logic [IDX_W-1:0]       in_col;
  logic [VAL_W-1:0]       in_val;
  logic                   in_inside;
  logic [AW-1:0]          in_addr;
  logic                   in_acc;

  assign in_mode   = mode_e'(s_axis_tdata_i[1:0]);
  assign in_row    = s_axis_tdata_i[5:2];
  assign in_col    = s_axis_tdata_i[9:6];
  assign in_val    = s_axis_tdata_i[25:10];
  assign in_inside = (32'(in_row) < Dim) && (32'(in_col) < Dim);
  assign in_addr   = base_tab[blk_tab[in_row]][blk_tab[in_col]]
                   + AW'(elem_off(sub_tab[in_row], sub_tab[in_col]));
  assign in_acc    = s_axis_tvalid_i & s_axis_tready_o;

  // control
  state_e               state_q;
  logic                 out_valid_q;
  logic [RES_W-1:0]     out_data_q;
  logic                 out_stat_q;
  logic                 res_valid_q;
  logic                 computed_q;
  logic                 rd_inside_q;
  logic                 rd_stat_q;
  logic [DRAIN_W-1:0]   drain_q;
  logic [BW-1:0]        ci_q, cj_q, k_q;
  logic [EW-1:0]        r_q, c_q, t_q;

  logic t_end, k_end, c_end, r_end, j_end, i_end;
  assign t_end = (32'(t_q) == BlockSize - 1);
  assign k_end = (32'(k_q) == NumBlocks - 1);
  assign c_end = (32'(c_q) == BlockSize - 1);
  assign r_end = (32'(r_q) == BlockSize - 1);
  assign j_end = (cj_q == ci_q);
  assign i_end = (32'(ci_q) == NumBlocks - 1);

  assign s_axis_tready_o = (state_q == ST_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_stat_q;

  // operand memories, two copies each for two reads per cycle
  logic          we_a, we_b;
  logic [AW-1:0] ra0, ra1, rb0, rb1;
  logic [VAL_W-1:0] da0, da1, db0, db1;

  assign we_a = in_acc && (in_mode == MODE_WR_A) && in_inside;
  assign we_b = in_acc && (in_mode == MODE_WR_B) && in_inside;
  assign ra0  = base_tab[ci_q][k_q] + AW'(elem_off(r_q, t_q));
  assign ra1  = base_tab[cj_q][k_q] + AW'(elem_off(r_q, t_q));
  assign rb0  = base_tab[k_q][cj_q] + AW'(elem_off(t_q, c_q));
  assign rb1  = base_tab[k_q][ci_q] + AW'(elem_off(t_q, c_q));

  pbp_ram #(.Width(VAL_W), .Depth(Depth)) u_ram_a0 (
    .clk_i, .we_i(we_a), .waddr_i(in_addr), .wdata_i(in_val), .raddr_i(ra0), .rdata_o(da0));
  pbp_ram #(.Width(VAL_W), .Depth(Depth)) u_ram_a1 (
    .clk_i, .we_i(we_a), .waddr_i(in_addr), .wdata_i(in_val), .raddr_i(ra1), .rdata_o(da1));
  pbp_ram #(.Width(VAL_W), .Depth(Depth)) u_ram_b0 (
    .clk_i, .we_i(we_b), .waddr_i(in_addr), .wdata_i(in_val), .raddr_i(rb0), .rdata_o(db0));
  pbp_ram #(.Width(VAL_W), .Depth(Depth)) u_ram_b1 (
    .clk_i, .we_i(we_b), .waddr_i(in_addr), .wdata_i(in_val), .raddr_i(rb1), .rdata_o(db1));

  // issue tags aligned with memory read data
  logic          iss_valid_q, iss_first_q, iss_last_q;
  logic [AW-1:0] iss_caddr_q;
  logic          issuing;
  assign issuing = (state_q == ST_RUN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_valid_q <= 1'b0;
    end else begin
      iss_valid_q <= issuing;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_first_q <= (k_q == '0) && (t_q == '0);
    iss_last_q  <= k_end && t_end;
    iss_caddr_q <= base_tab[ci_q][cj_q] + AW'(elem_off(r_q, c_q));
  end

  // multiply-add chain
  stage_t        st  [CHAIN_LEN+1];
  logic [AW-1:0] tag [CHAIN_LEN+1];

  always_comb begin
    st[0]       = '0;
    st[0].valid = iss_valid_q;
    st[0].first = iss_first_q;
    st[0].last  = iss_last_q;
    st[0].a[0]  = da0;
    st[0].a[1]  = da1;
    st[0].b[0]  = db0;
    st[0].b[1]  = db1;
  end
  assign tag[0] = iss_caddr_q;

  for (genvar n = 0; n < CHAIN_LEN; n++) begin : g_chain
    pbp_mac_cell #(.Idx(n), .TagW(AW)) u_cell (
      .clk_i, .rst_ni,
      .stage_i(st[n]), .tag_i(tag[n]),
      .stage_o(st[n+1]), .tag_o(tag[n+1]));
  end

  // element accumulator and result memory
  logic signed [RES_W-1:0] acc_q, acc_d;
  logic                    we_c;
  logic [RES_W-1:0]        dc;

  assign acc_d = (st[CHAIN_LEN].first ? '0 : acc_q) + st[CHAIN_LEN].sum;
  assign we_c  = st[CHAIN_LEN].valid && st[CHAIN_LEN].last;

  always_ff @(posedge clk_i) begin
    if (st[CHAIN_LEN].valid) begin
      acc_q <= acc_d;
    end
  end

  pbp_ram #(.Width(RES_W), .Depth(Depth)) u_ram_c (
    .clk_i, .we_i(we_c), .waddr_i(tag[CHAIN_LEN]), .wdata_i(acc_d),
    .raddr_i(in_addr), .rdata_o(dc));

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_stat_q  <= 1'b0;
      res_valid_q <= 1'b0;
      computed_q  <= 1'b0;
      rd_inside_q <= 1'b0;
      rd_stat_q   <= 1'b0;
      drain_q     <= '0;
      ci_q        <= '0;
      cj_q        <= '0;
      k_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      t_q         <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              MODE_WR_A, MODE_WR_B: begin
                if (in_inside) begin
                  res_valid_q <= 1'b0;
                end
                out_valid_q <= 1'b1;
                out_data_q  <= '0;
                out_stat_q  <= 1'b0;
              end
              MODE_COMPUTE: begin
                ci_q    <= '0;
                cj_q    <= '0;
                k_q     <= '0;
                r_q     <= '0;
                c_q     <= '0;
                t_q     <= '0;
                state_q <= ST_RUN;
              end
              default: begin
                rd_inside_q <= in_inside;
                rd_stat_q   <= !res_valid_q;
                state_q     <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_q <= 1'b1;
          out_data_q  <= (computed_q && rd_inside_q) ? dc : '0;
          out_stat_q  <= rd_stat_q;
          state_q     <= ST_IDLE;
        end
        ST_RUN: begin
          t_q <= t_end ? '0 : t_q + 1'b1;
          if (t_end) begin
            k_q <= k_end ? '0 : k_q + 1'b1;
            if (k_end) begin
              c_q <= c_end ? '0 : c_q + 1'b1;
              if (c_end) begin
                r_q <= r_end ? '0 : r_q + 1'b1;
                if (r_end) begin
                  cj_q <= j_end ? '0 : cj_q + 1'b1;
                  if (j_end) begin
                    ci_q <= ci_q + 1'b1;
                    if (i_end) begin
                      ci_q    <= '0;
                      drain_q <= DRAIN_W'(DRAIN_CYC);
                      state_q <= ST_DRAIN;
                    end
                  end
                end
              end
            end
          end
        end
        ST_DRAIN: begin
          drain_q <= drain_q - 1'b1;
          if (drain_q == DRAIN_W'(1)) begin
            out_valid_q <= 1'b1;
            out_data_q  <= '0;
            out_stat_q  <= 1'b0;
            res_valid_q <= 1'b1;
            computed_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/symmetry_preserving_block_product_top_tb.sv]
module symmetry_preserving_block_product_top_tb;
  import pbp_pkg::*;

  localparam int NB     = NUM_BLOCKS_DEF;
  localparam int BS     = BLOCK_SIZE_DEF;
  localparam int BSQ    = BS * BS;
  localparam int NCELLS = NB * (NB + 1) / 2;
  localparam int LIMIT  = 800000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [RES_W-1:0]      m_axis_tdata_o;
  logic                  m_axis_tuser_o;

  symmetry_preserving_block_product_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  typedef struct {
    logic [RES_W-1:0] value;
    logic             stale;
  } resp_t;

  logic [IN_TDATA_W-1:0] pending_reqs[$];
  resp_t                 expected_resps[$];

  longint a_cells[NCELLS][BSQ];
  longint b_cells[NCELLS][BSQ];
  longint c_cells[NCELLS][BSQ];
  bit     product_fresh;

  int  cyc;
  int  errors;
  bit  req_taken;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int cell_idx(int i, int j);
    int hi;
    int lo;
    hi = (i > j) ? i : j;
    lo = (i > j) ? j : i;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  task automatic form_product();
    longint s;
    for (int bi = 0; bi < NB; bi++) begin
      for (int bj = 0; bj <= bi; bj++) begin
        for (int e = 0; e < BSQ; e++) begin
          s = 0;
          for (int k = 0; k < NB; k++) begin
            for (int t = 0; t < BS; t++) begin
              s += a_cells[cell_idx(bi, k)][(e / BS) * BS + t] *
                   b_cells[cell_idx(k, bj)][t * BS + e % BS];
              s += a_cells[cell_idx(bj, k)][(e / BS) * BS + t] *
                   b_cells[cell_idx(k, bi)][t * BS + e % BS];
            end
          end
          c_cells[cell_idx(bi, bj)][e] = s;
        end
      end
    end
  endtask

  task automatic apply_request(logic [IN_TDATA_W-1:0] d);
    mode_e         mode;
    int            row;
    int            col;
    int            c;
    int            off;
    logic [15:0]   v;
    resp_t         r;
    mode = mode_e'(d[1:0]);
    row  = d[5:2];
    col  = d[9:6];
    v    = d[25:10];
    c    = cell_idx(row / BS, col / BS);
    off  = (row % BS) * BS + col % BS;
    r.value = '0;
    r.stale = 1'b0;
    case (mode)
      MODE_WR_A: begin
        a_cells[c][off] = longint'($signed(v));
        product_fresh = 1'b0;
      end
      MODE_WR_B: begin
        b_cells[c][off] = longint'($signed(v));
        product_fresh = 1'b0;
      end
      MODE_COMPUTE: begin
        form_product();
        product_fresh = 1'b1;
      end
      default: begin
        r.value = c_cells[c][off][RES_W-1:0];
        r.stale = !product_fresh;
      end
    endcase
    expected_resps.insert(expected_resps.size(), r);
  endtask

  function automatic bit idle_now();
    return (cyc < 6000 || cyc > 40000) && ($urandom_range(99) < 12);
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("symmetry_preserving_block_product_top_tb: done, errors");
      $finish;
    end
    req_taken = s_axis_tvalid_i && s_axis_tready_o;
    if (req_taken) apply_request(s_axis_tdata_i);
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_resps.size() == 0) begin
        $display("%0t unexpected response value=%h status=%b", $time,
                 m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        if (m_axis_tdata_o !== expected_resps[0].value) begin
          $display("%0t result_value expected %h actual %h", $time,
                   expected_resps[0].value, m_axis_tdata_o);
          errors++;
        end
        if (m_axis_tuser_o !== expected_resps[0].stale) begin
          $display("%0t status expected %b actual %b", $time,
                   expected_resps[0].stale, m_axis_tuser_o);
          errors++;
        end
        void'(expected_resps.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || req_taken) begin
        if (pending_reqs.size() > 0 && !idle_now()) begin
          s_axis_tdata_i  <= pending_reqs.pop_front();
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= !idle_now();
    end
  end

  task automatic push_req(mode_e mode, int row, int col, logic [15:0] v);
    pending_reqs.insert(pending_reqs.size(), {6'b0, v, col[3:0], row[3:0], mode});
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic fill_all(bit extreme);
    int r;
    int c;
    for (int hi = 0; hi < NB; hi++) begin
      for (int lo = 0; lo <= hi; lo++) begin
        for (int e = 0; e < BSQ; e++) begin
          for (int m = 0; m < 2; m++) begin
            if ($urandom_range(1)) begin
              r = hi * BS + e / BS;
              c = lo * BS + e % BS;
            end else begin
              r = lo * BS + e / BS;
              c = hi * BS + e % BS;
            end
            push_req(m ? MODE_WR_B : MODE_WR_A, r, c,
                     extreme ? ((e % 3 == 0) ? 16'h7fff : 16'h8000) : pick_value());
          end
        end
      end
    end
  endtask

  initial begin
    int sel;
    cyc    = 0;
    errors = 0;
    product_fresh = 1'b0;
    for (int p = 0; p < NCELLS; p++) begin
      for (int e = 0; e < BSQ; e++) begin
        a_cells[p][e] = 0;
        b_cells[p][e] = 0;
        c_cells[p][e] = 0;
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reads before any compute: zero and stale
    push_req(MODE_READ, 0, 0, 16'hffff);
    push_req(MODE_READ, 15, 15, 16'h0);
    // extreme operands
    fill_all(1'b1);
    push_req(MODE_COMPUTE, 0, 0, 16'h0);
    push_req(MODE_READ, 0, 0, 16'h0);
    push_req(MODE_READ, 15, 15, 16'h0);
    push_req(MODE_READ, 2, 13, 16'h0);
    push_req(MODE_READ, 13, 2, 16'h0);
    push_req(MODE_WR_A, 5, 9, 16'h1234);
    push_req(MODE_READ, 5, 9, 16'h0);
    push_req(MODE_COMPUTE, 3, 3, 16'hffff);
    push_req(MODE_READ, 9, 5, 16'h0);
    fill_all(1'b0);
    push_req(MODE_COMPUTE, 0, 0, 16'h0);

    for (int n = 0; n < 400; n++) begin
      sel = $urandom_range(99);
      if (sel < 3)
        push_req(MODE_COMPUTE, $urandom_range(15), $urandom_range(15), 16'($urandom));
      else if (sel < 48)
        push_req(sel[0] ? MODE_WR_B : MODE_WR_A, $urandom_range(15), $urandom_range(15),
                 pick_value());
      else
        push_req(MODE_READ, $urandom_range(15), $urandom_range(15), 16'($urandom));
    end

    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_resps.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && expected_resps.size() == 0)
      $display("symmetry_preserving_block_product_top_tb: done, clean");
    else
      $display("symmetry_preserving_block_product_top_tb: done, errors");
    $finish;
  end

endmodule
